// ===== src/bphe_pkg.sv =====
// Package for the button press/hold event block: widths, register indexes,
// reset values and the result record. No dependencies.
package bphe_pkg;

	// timestamp and threshold width in bits
	localparam int unsigned TsW = 64;

	// configuration register index width and codes
	localparam int unsigned CfgIdxW = 2;
	typedef enum logic [CfgIdxW-1:0] {
		CFG_ACTIVE_LEVEL = 2'd0,
		CFG_HOLD_ENABLE  = 2'd1,
		CFG_HOLD_THRESH  = 2'd2
	} cfg_idx_t;

	// reset values
	localparam logic [TsW-1:0] HoldThreshRst  = TsW'(64'd1000000);
	localparam logic           ActiveLevelRst = 1'b0;
	localparam logic           HoldEnableRst  = 1'b0;
	localparam logic           PrevRawRst     = 1'b1;

	// one result record
	typedef struct packed {
		logic down_event;
		logic up_event;
		logic pressed_event;
		logic held_event;
		logic is_pressed;
	} bphe_result_t;

endpackage

// ===== src/bphe_if.sv =====
// Channel interfaces for the button press/hold event block.
// Depends on bphe_pkg for the timestamp width.

// poll channel: one sample of the pin with its timestamp
interface bphe_poll_if;
	import bphe_pkg::*;

	logic           valid;
	logic           ready;
	logic           pin_level;
	logic [TsW-1:0] now_us;

	modport source (output valid, output pin_level, output now_us, input ready);
	modport sink   (input valid, input pin_level, input now_us, output ready);
endinterface

// event channel: one result record per poll
interface bphe_evt_if;
	logic valid;
	logic ready;
	logic down_event;
	logic up_event;
	logic pressed_event;
	logic held_event;
	logic is_pressed;

	modport source (output valid, output down_event, output up_event,
		output pressed_event, output held_event, output is_pressed, input ready);
	modport sink   (input valid, input down_event, input up_event,
		input pressed_event, input held_event, input is_pressed, output ready);
endinterface

// ===== src/button_press_hold_events.sv =====
// Top level of the button press/hold event detector.
// Depends on bphe_pkg and the channel interfaces in bphe_if.sv.
//
//  channel | dir | payload                                        | handshake
//  poll    | in  | pin_level, now_us[63:0]                        | valid/ready
//  evt     | out | down, up, pressed, held events; is_pressed     | valid/ready
//  cfg     | in  | cfg_we, cfg_index[1:0], cfg_data[63:0]         | write enable
//
// One poll per clock while the output is not stalled. A poll is taken into an
// input register (_s1); from there the edge logic and the 64-bit elapsed-time
// subtract and compare produce the result into the output register (_s2) and
// update the state.
// arst_n clears the press state and loads the register reset values.
// A stalled output holds both stages; the input register refills as soon as
// its item moves to the output register.
module button_press_hold_events (
	input  logic                        clk,
	input  logic                        arst_n,
	bphe_poll_if.sink                   poll,
	bphe_evt_if.source                  evt,
	input  logic                        cfg_we,
	input  logic [bphe_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bphe_pkg::TsW-1:0]     cfg_data
);
	import bphe_pkg::*;

	// configuration registers
	logic           active_level_q;
	logic           hold_enable_q;
	logic [TsW-1:0] hold_thresh_q;

	// detector state
	logic           prev_raw_q;
	logic           pressed_q;
	logic [TsW-1:0] press_start_q;
	logic           hold_fired_q;
	logic           rel_suppress_q;

	// pipeline registers
	logic           valid_s1;
	logic           raw_s1;
	logic [TsW-1:0] now_s1;
	logic           valid_s2;
	bphe_result_t   res_s2;

	// stage control
	logic adv_s1;
	logic take_s1;

	// step logic
	logic           change;
	logic           raw_active;
	logic           press_now;
	logic           release_now;
	logic [TsW-1:0] elapsed;
	logic           reached;
	logic           pressed_nx;
	logic           fired_eff;
	logic           held;
	bphe_result_t   res_nx;

	// handshake: s1 moves on when the output register is empty or drained
	assign adv_s1     = valid_s1 && (!valid_s2 || evt.ready);
	assign take_s1    = poll.valid && poll.ready;
	assign poll.ready = !valid_s1 || adv_s1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q <= ActiveLevelRst;
			hold_enable_q  <= HoldEnableRst;
			hold_thresh_q  <= HoldThreshRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_LEVEL: active_level_q <= cfg_data[0];
				CFG_HOLD_ENABLE:  hold_enable_q  <= cfg_data[0];
				CFG_HOLD_THRESH:  hold_thresh_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			raw_s1 <= poll.pin_level;
			now_s1 <= poll.now_us;
		end
	end

	// edge detection and hold check
	always_comb begin
		change      = raw_s1 != prev_raw_q;
		raw_active  = raw_s1 == active_level_q;
		press_now   = change && raw_active;
		release_now = change && !raw_active && pressed_q;
		pressed_nx  = change ? raw_active : pressed_q;
		// a press on this poll restarts the clock, so elapsed time is zero
		elapsed     = now_s1 - press_start_q;
		reached     = press_now ? (hold_thresh_q == '0) : (elapsed >= hold_thresh_q);
		fired_eff   = press_now ? !hold_enable_q : hold_fired_q;
		held        = pressed_nx && hold_enable_q && !fired_eff && reached;

		res_nx.down_event    = press_now && !pressed_q;
		res_nx.up_event      = release_now && !rel_suppress_q;
		res_nx.pressed_event = release_now && !rel_suppress_q;
		res_nx.held_event    = held;
		res_nx.is_pressed    = pressed_nx;
	end

	// state update on each processed poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q     <= PrevRawRst;
			pressed_q      <= 1'b0;
			hold_fired_q   <= 1'b0;
			rel_suppress_q <= 1'b0;
		end else if (adv_s1) begin
			prev_raw_q   <= raw_s1;
			pressed_q    <= pressed_nx;
			hold_fired_q <= fired_eff || held;
			if (held) begin
				rel_suppress_q <= 1'b1;
			end else if (release_now) begin
				rel_suppress_q <= 1'b0;
			end
		end
	end

	// press timestamp, meaningful only while pressed
	always_ff @(posedge clk) begin
		if (adv_s1 && press_now) begin
			press_start_q <= now_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || evt.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nx;
		end
	end

	assign evt.valid         = valid_s2;
	assign evt.down_event    = res_s2.down_event;
	assign evt.up_event      = res_s2.up_event;
	assign evt.pressed_event = res_s2.pressed_event;
	assign evt.held_event    = res_s2.held_event;
	assign evt.is_pressed    = res_s2.is_pressed;

endmodule

// ===== dv/tb_button_press_hold_events.sv =====
// Self-checking testbench for button_press_hold_events: polls go in through a queue-fed
// driver, results are checked against an in-bench event tracker as they leave the block.
// Depends on bphe_pkg, the channel interfaces in bphe_if.sv and the block itself.
module tb_button_press_hold_events;
	import bphe_pkg::*;

	localparam logic [TsW-1:0] TsMax = {TsW{1'b1}};

	typedef struct {
		logic           pin;
		logic [TsW-1:0] now;
	} poll_item_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [TsW-1:0]      cfg_data;

	bphe_poll_if poll_ch ();
	bphe_evt_if  evt_ch ();

	button_press_hold_events dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_ch),
		.evt       (evt_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock, period 4
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// polls waiting to be offered and event records waiting to come out
	poll_item_t   pending_polls[$];
	bphe_result_t expected_evts[$];
	int unsigned  mismatches = 0;

	// idling controls
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	logic        rx_hold   = 1'b0;
	logic        squeeze_go = 1'b0;

	// tracker copy of the configuration
	logic           act_lvl     = ActiveLevelRst;
	logic           hold_en     = HoldEnableRst;
	logic [TsW-1:0] hold_thresh = HoldThreshRst;

	// tracker copy of the button state
	logic           last_pin     = PrevRawRst;
	logic           btn_down     = 1'b0;
	logic [TsW-1:0] down_at      = '0;
	logic           hold_done    = 1'b0;
	logic           mute_release = 1'b0;

	// stimulus generator state
	logic           gen_pin    = PrevRawRst;
	logic [TsW-1:0] gen_t      = '0;
	logic [TsW-1:0] gen_edge_t = '0;

	// advance the button tracker by one poll and return the events it gives
	function automatic bphe_result_t track_button(logic pin, logic [TsW-1:0] now);
		bphe_result_t r;
		logic         was_down;
		r = '0;
		was_down = btn_down;
		if (pin != last_pin) begin
			if (pin == act_lvl) begin
				btn_down  = 1'b1;
				down_at   = now;
				hold_done = !hold_en;
			end else begin
				btn_down = 1'b0;
			end
			if (!was_down && btn_down)
				r.down_event = 1'b1;
			if (was_down && !btn_down) begin
				// a release after a held event only clears the mark
				if (!mute_release) begin
					r.up_event      = 1'b1;
					r.pressed_event = 1'b1;
				end else begin
					mute_release = 1'b0;
				end
			end
		end
		// elapsed time is the wrapped difference
		if (btn_down && hold_en && !hold_done && (now - down_at) >= hold_thresh) begin
			hold_done    = 1'b1;
			mute_release = 1'b1;
			r.held_event = 1'b1;
		end
		last_pin     = pin;
		r.is_pressed = btn_down;
		return r;
	endfunction

	function automatic void check_field(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			mismatches++;
		end
	endfunction

	// poll driver: holds an offered item until its transfer
	always @(posedge clk) begin : poll_driver
		logic keep;
		if (arst_n) begin
			if (poll_ch.valid && poll_ch.ready) begin
				expected_evts.push_back(track_button(poll_ch.pin_level, poll_ch.now_us));
				void'(pending_polls.pop_front());
			end
			keep = poll_ch.valid && !poll_ch.ready;
			if (!keep) begin
				if (pending_polls.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					poll_ch.valid     <= 1'b1;
					poll_ch.pin_level <= pending_polls[0].pin;
					poll_ch.now_us    <= pending_polls[0].now;
				end else begin
					poll_ch.valid <= 1'b0;
				end
			end
		end
	end

	// event monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin : evt_monitor
		bphe_result_t want;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			if (expected_evts.size() == 0) begin
				$error("unexpected event record transfer");
				mismatches++;
			end else begin
				want = expected_evts.pop_front();
				check_field("down_event", want.down_event, evt_ch.down_event);
				check_field("up_event", want.up_event, evt_ch.up_event);
				check_field("pressed_event", want.pressed_event, evt_ch.pressed_event);
				check_field("held_event", want.held_event, evt_ch.held_event);
				check_field("is_pressed", want.is_pressed, evt_ch.is_pressed);
			end
		end
		evt_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
	end

	// long receiver hold-off so the pipeline fills and backs up the poll side
	initial begin
		wait (squeeze_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// wait until every poll is taken and every record has come out
	task automatic settle();
		while (pending_polls.size() != 0 || poll_ch.valid || expected_evts.size() != 0)
			@(posedge clk);
	endtask

	// register write, only issued while the block is idle
	task automatic set_reg(cfg_idx_t idx, logic [TsW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_ACTIVE_LEVEL: act_lvl = val[0];
			CFG_HOLD_ENABLE:  hold_en = val[0];
			CFG_HOLD_THRESH:  hold_thresh = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_poll(logic pin, logic [TsW-1:0] now);
		poll_item_t it;
		it.pin = pin;
		it.now = now;
		pending_polls.push_back(it);
		if (pin != gen_pin)
			gen_edge_t = now;
		gen_pin = pin;
		gen_t   = now;
	endtask

	// random poll: mostly press/release traffic with times near the hold threshold
	task automatic gen_poll();
		logic           pin;
		logic [TsW-1:0] now;
		int unsigned    r;
		r   = $urandom_range(0, 99);
		pin = gen_pin;
		if (r < 30)
			pin = ~gen_pin;
		else if (r >= 95)
			pin = 1'($urandom_range(0, 1));
		now = gen_t;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: now = gen_t + TsW'($urandom_range(0, 3));
			4, 5, 6:    now = gen_edge_t + hold_thresh + TsW'($urandom_range(0, 2)) - 64'd1;
			7:          now = {$urandom, $urandom};
			8:          now = gen_t + ({$urandom, $urandom} >> $urandom_range(0, 63));
			default: ;
		endcase
		queue_poll(pin, now);
	endtask

	task automatic run_phase(logic act, logic en, logic [TsW-1:0] thr,
			int unsigned snd, int unsigned rcv, int unsigned n);
		settle();
		set_reg(CFG_ACTIVE_LEVEL, TsW'(act));
		set_reg(CFG_HOLD_ENABLE, TsW'(en));
		set_reg(CFG_HOLD_THRESH, thr);
		idle_pct  <= snd;
		stall_pct <= rcv;
		repeat (n) gen_poll();
	endtask

	// stimulus
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_ACTIVE_LEVEL;
		cfg_data          = '0;
		poll_ch.valid     = 1'b0;
		poll_ch.pin_level = 1'b0;
		poll_ch.now_us    = '0;
		evt_ch.ready      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: plain press and release, hold disabled
		queue_poll(1'b1, '0);
		queue_poll(1'b0, 64'd5);
		queue_poll(1'b0, 64'd10);
		queue_poll(1'b1, 64'd20);
		queue_poll(1'b1, TsMax);

		// zero threshold: held in the same poll as the press, release muted
		settle();
		set_reg(CFG_HOLD_ENABLE, 64'd1);
		set_reg(CFG_HOLD_THRESH, '0);
		queue_poll(1'b0, TsMax);
		queue_poll(1'b1, '0);
		queue_poll(1'b0, 64'd100);

		// largest threshold: reached only by a full wrap of the timestamp
		settle();
		set_reg(CFG_HOLD_THRESH, TsMax);
		queue_poll(1'b1, 64'd200);
		queue_poll(1'b0, 64'd1000);
		queue_poll(1'b0, 64'd999);
		queue_poll(1'b1, 64'd1001);

		// reset threshold across the timestamp wrap, one short of it then on it
		settle();
		set_reg(CFG_HOLD_THRESH, HoldThreshRst);
		queue_poll(1'b0, TsMax - 64'd9);
		queue_poll(1'b0, 64'd999_989);
		queue_poll(1'b0, 64'd999_990);
		queue_poll(1'b1, 64'd1_000_000);

		// active high: change to inactive while released, then a press
		settle();
		set_reg(CFG_ACTIVE_LEVEL, 64'd1);
		queue_poll(1'b0, 64'd1_000_010);
		queue_poll(1'b1, 64'd1_000_020);

		// flip the active level mid-press: press again while pressed, then release
		settle();
		set_reg(CFG_ACTIVE_LEVEL, 64'd0);
		queue_poll(1'b0, 64'd1_000_030);
		queue_poll(1'b1, 64'd1_000_040);

		// hold enabled only after the press started: no held event for it
		settle();
		set_reg(CFG_HOLD_ENABLE, 64'd0);
		queue_poll(1'b0, 64'd1_000_050);
		settle();
		set_reg(CFG_HOLD_ENABLE, 64'd1);
		queue_poll(1'b0, 64'd9_000_000);
		queue_poll(1'b1, 64'd9_000_010);

		// random phases; the first runs flat out with a long receiver hold-off
		settle();
		squeeze_go = 1'b1;
		run_phase(1'b0, 1'b1, HoldThreshRst, 0, 0, 235);
		run_phase(1'b1, 1'b1, '0, 83, 0, 235);
		run_phase(1'b0, 1'b0, 64'd5, 0, 83, 235);
		run_phase(1'b1, 1'b1, TsMax, 25, 25, 235);
		run_phase(1'b0, 1'b1, 64'd1, 0, 0, 235);
		run_phase(1'b1, 1'b1, {$urandom, $urandom}, 83, 0, 235);
		run_phase(1'b0, 1'b1, TsW'($urandom_range(0, 50)), 0, 83, 235);
		run_phase(1'b1, 1'b0, {$urandom, $urandom}, 25, 25, 235);

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("[button_press_hold_events] OK");
		end else begin
			$display("[button_press_hold_events] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("[button_press_hold_events] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
src/bphe_pkg.sv
src/bphe_if.sv
src/button_press_hold_events.sv
dv/tb_button_press_hold_events.sv
